@@ rtl/chs_pkg.sv @@
// Package for the cosine hemisphere sampler: types, constants and helpers.
package chs_pkg;

    // Default configuration
    localparam int SampleBitsDef   = 16;
    localparam int CordicStepsDef  = 16;
    localparam int CordicStepsMax  = 24;
    localparam int QuotBits        = 31;   // Q30 ratio, value up to 1.0
    localparam int SqrtSteps       = 32;   // root digits of a 64-bit radicand

    // Q30 constants; the pdf ceiling PdfMax is 1/pi in Q16
    localparam logic [29:0] Pi4Q30   = 30'd843314857;
    localparam logic [29:0] GainQ30  = 30'd652032874;
    localparam logic [28:0] InvPiQ30 = 29'd341782638;
    localparam logic [14:0] PdfMax   = 15'd20861;

    // CORDIC arctangent table, Q30
    localparam logic [29:0] AtanQ30 [CordicStepsMax] = '{
        30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159,
        30'd67021687,  30'd33543516,  30'd16775851,  30'd8388437,
        30'd4194283,   30'd2097149,   30'd1048576,   30'd524288,
        30'd262144,    30'd131072,    30'd65536,     30'd32768,
        30'd16384,     30'd8192,      30'd4096,      30'd2048,
        30'd1024,      30'd512,       30'd256,       30'd128
    };

    // Data that rides along with each request until the disk point is known
    typedef struct packed {
        logic               zero;   // square point is the exact origin
        logic               xr;     // x axis supplies the radius
        logic               neg;    // ratio is negative
        logic signed [31:0] r;      // radius, Q30
    } t_side;

    // Divider cell state
    typedef struct packed {
        logic                  valid;
        logic [31:0]           rem;
        logic [30:0]           den;
        logic [QuotBits-1:0]   q;
        t_side                 side;
    } t_div;

    // CORDIC cell state
    typedef struct packed {
        logic               valid;
        logic signed [33:0] x;
        logic signed [33:0] y;
        logic signed [33:0] z;
        t_side              side;
    } t_cor;

    // Square-root cell state
    typedef struct packed {
        logic               valid;
        logic [63:0]        m;      // radicand, consumed two bits per cell
        logic [33:0]        rem;
        logic [31:0]        root;
        logic signed [15:0] sx;
        logic signed [15:0] sy;
    } t_sq;

    // Cycles from an accepted request to its result strobe
    function automatic int chs_latency(input int steps);
        return 70 + steps;
    endfunction

    // Q30 to Q15, round half up, saturate to signed 16 bits
    function automatic logic signed [15:0] f_sat_q15(input logic signed [32:0] v);
        logic signed [33:0] t;
        t = (34'(v) + 34'sd16384) >>> 15;
        if (t > 34'sd32767) begin
            return 16'sh7fff;
        end else if (t < -34'sd32768) begin
            return 16'sh8000;
        end
        return 16'(t);
    endfunction

endpackage

@@ rtl/chs_div_cell.sv @@
// One restoring-division cell: one quotient bit of the Q30 axis ratio.
module chs_div_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  chs_pkg::t_div  i_d,
    output chs_pkg::t_div  o_d
);
    import chs_pkg::*;

    logic        w_ge;
    logic [31:0] w_rem;
    t_div        n_d;
    t_div        r_d;

    // compare, subtract, shift
    always_comb begin
        w_ge  = i_d.rem >= {1'b0, i_d.den};
        w_rem = w_ge ? (i_d.rem - {1'b0, i_d.den}) : i_d.rem;
        n_d       = i_d;
        n_d.rem   = {w_rem[30:0], 1'b0};
        n_d.q     = {i_d.q[QuotBits-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        r_d <= n_d;
        if (!i_rst_n) begin
            r_d.valid <= 1'b0;
        end
    end

    assign o_d = r_d;
endmodule

@@ rtl/chs_cordic_cell.sv @@
// One CORDIC rotation cell for a fixed step index.
module chs_cordic_cell #(
    parameter int STEP = 0
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  chs_pkg::t_cor  i_c,
    output chs_pkg::t_cor  o_c
);
    import chs_pkg::*;

    logic signed [33:0] w_xs;
    logic signed [33:0] w_ys;
    logic signed [33:0] w_at;
    t_cor               n_c;
    t_cor               r_c;

    // rotate toward zero residual angle; shifts floor
    always_comb begin
        w_xs = i_c.x >>> STEP;
        w_ys = i_c.y >>> STEP;
        w_at = $signed({4'b0, AtanQ30[STEP]});
        n_c  = i_c;
        if (!i_c.z[33]) begin
            n_c.x = i_c.x - w_ys;
            n_c.y = i_c.y + w_xs;
            n_c.z = i_c.z - w_at;
        end else begin
            n_c.x = i_c.x + w_ys;
            n_c.y = i_c.y - w_xs;
            n_c.z = i_c.z + w_at;
        end
    end

    always_ff @(posedge i_clk) begin
        r_c <= n_c;
        if (!i_rst_n) begin
            r_c.valid <= 1'b0;
        end
    end

    assign o_c = r_c;
endmodule

@@ rtl/chs_sqrt_cell.sv @@
// One digit-by-digit square-root cell: one root bit per cell.
module chs_sqrt_cell (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  chs_pkg::t_sq  i_s,
    output chs_pkg::t_sq  o_s
);
    import chs_pkg::*;

    logic [33:0] w_rem;
    logic [33:0] w_trial;
    t_sq         n_s;
    t_sq         r_s;

    // bring down two radicand bits and try the next root bit
    always_comb begin
        w_rem   = {i_s.rem[31:0], i_s.m[63:62]};
        w_trial = {i_s.root, 2'b01};
        n_s     = i_s;
        n_s.m   = {i_s.m[61:0], 2'b00};
        if (w_rem >= w_trial) begin
            n_s.rem  = w_rem - w_trial;
            n_s.root = {i_s.root[30:0], 1'b1};
        end else begin
            n_s.rem  = w_rem;
            n_s.root = {i_s.root[30:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        r_s <= n_s;
        if (!i_rst_n) begin
            r_s.valid <= 1'b0;
        end
    end

    assign o_s = r_s;
endmodule

@@ rtl/cosine_hemisphere_sampler.sv @@
// Top level of the cosine-weighted hemisphere sampler pipeline.
// Takes one sample pair per cycle whenever start is high (busy stays low) and
// strobes o_valid with the matching direction and pdf once the request has passed
// the chain of cells: 31 divider cells for the axis ratio, CORDIC_STEPS rotation
// cells, 32 root cells, plus the conversion, multiply and output registers. Each
// result is on the outputs for one cycle only; the receiver cannot stall it and
// must take it.
module cosine_hemisphere_sampler #(
    parameter int SAMPLE_BITS  = chs_pkg::SampleBitsDef,
    parameter int CORDIC_STEPS = chs_pkg::CordicStepsDef
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [15:0]        i_u_x,
    input  logic [15:0]        i_u_y,
    output logic               o_valid,
    output logic signed [15:0] o_dir_x,
    output logic signed [15:0] o_dir_y,
    output logic [14:0]        o_dir_z,
    output logic [14:0]        o_pdf
);
    import chs_pkg::*;

    localparam logic [15:0] SampleMask = 16'((33'd1 << SAMPLE_BITS) - 33'd1);

    t_div w_div [QuotBits+1];
    t_cor w_cor [CORDIC_STEPS+1];
    t_sq  w_sq  [SqrtSteps+1];

    // map samples to the square [-1,1)^2 in Q30
    logic [15:0]        w_ux, w_uy;
    logic signed [32:0] w_tx, w_ty;
    logic signed [31:0] w_ox, w_oy;
    logic [30:0]        w_ax, w_ay;
    logic               w_xr;
    t_div               n_div0;

    always_comb begin
        w_ux = i_u_x & SampleMask;
        w_uy = i_u_y & SampleMask;
        w_tx = $signed({16'b0, w_ux, 1'b0}) - $signed(33'd1 << SAMPLE_BITS);
        w_ty = $signed({16'b0, w_uy, 1'b0}) - $signed(33'd1 << SAMPLE_BITS);
        w_ox = 32'(w_tx <<< (30 - SAMPLE_BITS));
        w_oy = 32'(w_ty <<< (30 - SAMPLE_BITS));
        w_ax = 31'(w_ox[31] ? -w_ox : w_ox);
        w_ay = 31'(w_oy[31] ? -w_oy : w_oy);
        w_xr = w_ax > w_ay;
        n_div0.valid     = start;
        n_div0.rem       = {1'b0, w_xr ? w_ay : w_ax};
        n_div0.den       = w_xr ? w_ax : w_ay;
        n_div0.q         = '0;
        n_div0.side.zero = (w_ox == 32'sd0) && (w_oy == 32'sd0);
        n_div0.side.xr   = w_xr;
        n_div0.side.neg  = w_ox[31] ^ w_oy[31];
        n_div0.side.r    = w_xr ? w_ox : w_oy;
    end

    t_div r_div0;
    always_ff @(posedge i_clk) begin
        r_div0 <= n_div0;
        if (!i_rst_n) begin
            r_div0.valid <= 1'b0;
        end
    end
    assign w_div[0] = r_div0;

    // ratio divider chain
    for (genvar k = 0; k < QuotBits; k++) begin : g_div
        chs_div_cell u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_d    (w_div[k]),
            .o_d    (w_div[k+1])
        );
    end

    // angle = pi/4 * ratio, round half away from zero
    logic [60:0] w_aprod;
    logic [30:0] w_mag;
    t_cor        n_cor0;
    t_cor        r_cor0;

    always_comb begin
        w_aprod = 61'(w_div[QuotBits].q) * 61'(Pi4Q30);
        w_mag   = 31'((w_aprod + 61'd536870912) >> 30);
        n_cor0.valid = w_div[QuotBits].valid;
        n_cor0.x     = $signed({4'b0, GainQ30});
        n_cor0.y     = '0;
        n_cor0.z     = w_div[QuotBits].side.neg ? -$signed({3'b0, w_mag})
                                                :  $signed({3'b0, w_mag});
        n_cor0.side  = w_div[QuotBits].side;
    end

    always_ff @(posedge i_clk) begin
        r_cor0 <= n_cor0;
        if (!i_rst_n) begin
            r_cor0.valid <= 1'b0;
        end
    end
    assign w_cor[0] = r_cor0;

    // sine/cosine chain
    for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cor
        chs_cordic_cell #(.STEP(k)) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_c    (w_cor[k]),
            .o_c    (w_cor[k+1])
        );
    end

    // disk point = r * (cos, sin), axes swapped in the y-radius branch
    t_cor               w_cl;
    logic signed [65:0] w_pc, w_ps, w_rc, w_rs;
    logic signed [32:0] n_dx, n_dy, r_dx, r_dy;
    logic               r_v1;

    function automatic logic signed [32:0] f_sat33(input logic signed [65:0] v);
        if (v > 66'sd2147483648) begin
            return 33'sd2147483648;
        end else if (v < -66'sd2147483648) begin
            return -33'sd2147483648;
        end
        return 33'(v);
    endfunction

    always_comb begin
        w_cl = w_cor[CORDIC_STEPS];
        w_pc = 66'(w_cl.side.r) * 66'(w_cl.x);
        w_ps = 66'(w_cl.side.r) * 66'(w_cl.y);
        w_rc = (w_pc + 66'sd536870912) >>> 30;
        w_rs = (w_ps + 66'sd536870912) >>> 30;
        if (w_cl.side.zero) begin
            n_dx = '0;
            n_dy = '0;
        end else if (w_cl.side.xr) begin
            n_dx = f_sat33(w_rc);
            n_dy = f_sat33(w_rs);
        end else begin
            n_dx = f_sat33(w_rs);
            n_dy = f_sat33(w_rc);
        end
    end

    always_ff @(posedge i_clk) begin
        r_dx <= n_dx;
        r_dy <= n_dy;
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= w_cl.valid;
        end
    end

    // squares and rounded direction x, y
    logic [63:0]        r_sqx, r_sqy;
    logic signed [15:0] r_sx, r_sy;
    logic               r_v2;

    always_ff @(posedge i_clk) begin
        r_sqx <= 64'(66'(r_dx) * 66'(r_dx));
        r_sqy <= 64'(66'(r_dy) * 66'(r_dy));
        r_sx  <= f_sat_q15(r_dx);
        r_sy  <= f_sat_q15(r_dy);
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else begin
            r_v2 <= r_v1;
        end
    end

    // radicand = max(0, 1 - x^2 - y^2) in Q60
    logic signed [65:0] w_m;
    t_sq                n_sq0;
    t_sq                r_sq0;

    always_comb begin
        w_m = (66'sd1 <<< 60) - $signed({2'b0, r_sqx}) - $signed({2'b0, r_sqy});
        n_sq0.valid = r_v2;
        n_sq0.m     = w_m[65] ? 64'd0 : 64'(w_m);
        n_sq0.rem   = '0;
        n_sq0.root  = '0;
        n_sq0.sx    = r_sx;
        n_sq0.sy    = r_sy;
    end

    always_ff @(posedge i_clk) begin
        r_sq0 <= n_sq0;
        if (!i_rst_n) begin
            r_sq0.valid <= 1'b0;
        end
    end
    assign w_sq[0] = r_sq0;

    // integer square root chain
    for (genvar k = 0; k < SqrtSteps; k++) begin : g_sq
        chs_sqrt_cell u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_s    (w_sq[k]),
            .o_s    (w_sq[k+1])
        );
    end

    // pdf product
    logic [30:0]        r_zq;
    logic [59:0]        r_pprod;
    logic signed [15:0] r_sx3, r_sy3;
    logic               r_v3;

    always_ff @(posedge i_clk) begin
        r_zq    <= w_sq[SqrtSteps].root[30:0];
        r_pprod <= 60'(w_sq[SqrtSteps].root[30:0]) * 60'(InvPiQ30);
        r_sx3   <= w_sq[SqrtSteps].sx;
        r_sy3   <= w_sq[SqrtSteps].sy;
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else begin
            r_v3 <= w_sq[SqrtSteps].valid;
        end
    end

    // output register: round and saturate z and pdf
    logic [16:0] w_z15;
    logic [16:0] w_pdf;

    always_comb begin
        w_z15 = 17'((32'(r_zq) + 32'd16384) >> 15);
        w_pdf = 17'((r_pprod + 60'h800_0000_0000) >> 44);
    end

    always_ff @(posedge i_clk) begin
        o_dir_x <= r_sx3;
        o_dir_y <= r_sy3;
        o_dir_z <= (w_z15 > 17'd32767) ? 15'h7fff : w_z15[14:0];
        o_pdf   <= (w_pdf > 17'(PdfMax)) ? PdfMax : w_pdf[14:0];
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r_v3;
        end
    end

    // fully pipelined: never holds off a request
    assign busy = 1'b0;
endmodule

@@ rtl/chs_checker.sv @@
// Port-level checker for the hemisphere sampler and its bind.
module chs_checker #(
    parameter int SAMPLE_BITS  = chs_pkg::SampleBitsDef,
    parameter int CORDIC_STEPS = chs_pkg::CordicStepsDef
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_valid,
    input logic [14:0] o_dir_z,
    input logic [14:0] o_pdf
);
    import chs_pkg::*;

    localparam int Lat = chs_latency(CORDIC_STEPS);
    localparam int SampleLsb = SAMPLE_BITS;

    // pipeline never stalls a request
    a_no_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n) !busy)
        else $error("busy raised");

    // every result strobe traces back to a request a fixed latency earlier
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, Lat))
        else $error("result without matching request");

    // density never exceeds 1/pi
    a_pdf_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_pdf <= PdfMax))
        else $error("pdf out of range");

    // a large density implies a high z component
    a_pdf_z: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_pdf > 15'd20000) && (SampleLsb > 0)) |-> (o_dir_z > 15'd30000))
        else $error("pdf and z disagree");
endmodule

bind cosine_hemisphere_sampler chs_checker #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .CORDIC_STEPS(CORDIC_STEPS)
) u_chs_checker (
    .i_clk  (i_clk),
    .i_rst_n(i_rst_n),
    .start  (start),
    .busy   (busy),
    .o_valid(o_valid),
    .o_dir_z(o_dir_z),
    .o_pdf  (o_pdf)
);

@@ sim/tb_top.sv @@
// Testbench for the cosine hemisphere sampler: directed table plus random requests.
`timescale 1ns / 1ps

module tb_top;

    localparam int SampleBits  = chs_pkg::SampleBitsDef;
    localparam int CordicSteps = chs_pkg::CordicStepsDef;
    localparam int Latency     = 70 + CordicSteps;
    localparam int RandCount   = 400;

    typedef struct {
        logic signed [15:0] dir_x;
        logic signed [15:0] dir_y;
        logic [14:0]        dir_z;
        logic [14:0]        pdf;
    } t_dir;

    typedef struct {
        logic [15:0] u_x;
        logic [15:0] u_y;
        logic        known;   // expected value typed in below
        t_dir        dir;
    } t_row;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic [15:0]        i_u_x;
    logic [15:0]        i_u_y;
    logic               o_valid;
    logic signed [15:0] o_dir_x;
    logic signed [15:0] o_dir_y;
    logic [14:0]        o_dir_z;
    logic [14:0]        o_pdf;

    t_dir pending_dirs[$];
    int   mismatch_cnt;
    bit   stim_done;

    cosine_hemisphere_sampler #(
        .SAMPLE_BITS  (SampleBits),
        .CORDIC_STEPS (CordicSteps)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_u_x   (i_u_x),
        .i_u_y   (i_u_y),
        .o_valid (o_valid),
        .o_dir_x (o_dir_x),
        .o_dir_y (o_dir_y),
        .o_dir_z (o_dir_z),
        .o_pdf   (o_pdf)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Floor shift for signed values
    function automatic longint floor_shr(input longint v, input int s);
        return v >= 0 ? (v >>> s) : ~((~v) >>> s);
    endfunction

    function automatic longint clip(input longint v, input longint lo, input longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // Expected direction and density for one sample pair
    function automatic t_dir sample_direction(input logic [15:0] ux, input logic [15:0] uy);
        longint atan_tab[24] = '{843314857, 497837829, 263043837, 133525159, 67021687,
            33543516, 16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144,
            131072, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128};
        longint sq_x, sq_y, dx, dy, rad, num, den, quo, mag, ang, cx, sy, za, xs, ys;
        longint rem, zq, pd;
        longint unsigned root, trial;
        bit    x_major;
        t_dir  d;
        longint smask;
        smask = (longint'(1) << SampleBits) - 1;
        sq_x = (2 * (longint'(ux) & smask) - (longint'(1) << SampleBits))
               * (longint'(1) << (30 - SampleBits));
        sq_y = (2 * (longint'(uy) & smask) - (longint'(1) << SampleBits))
               * (longint'(1) << (30 - SampleBits));
        dx = 0;
        dy = 0;
        if (!(sq_x == 0 && sq_y == 0)) begin
            x_major = (sq_x < 0 ? -sq_x : sq_x) > (sq_y < 0 ? -sq_y : sq_y);
            rad = x_major ? sq_x : sq_y;
            num = x_major ? sq_y : sq_x;
            den = rad;
            quo = ((num < 0 ? -num : num) << 30) / (den < 0 ? -den : den);
            if ((num < 0) != (den < 0)) quo = -quo;
            mag = (843314857 * (quo < 0 ? -quo : quo) + (longint'(1) << 29)) >>> 30;
            ang = quo < 0 ? -mag : mag;
            // rotation steps
            cx = 652032874;
            sy = 0;
            za = ang;
            for (int i = 0; i < CordicSteps && i < 24; i++) begin
                xs = floor_shr(cx, i);
                ys = floor_shr(sy, i);
                if (za >= 0) begin
                    cx = cx - ys; sy = sy + xs; za = za - atan_tab[i];
                end else begin
                    cx = cx + ys; sy = sy - xs; za = za + atan_tab[i];
                end
            end
            if (x_major) begin
                dx = floor_shr(rad * cx + (longint'(1) << 29), 30);
                dy = floor_shr(rad * sy + (longint'(1) << 29), 30);
            end else begin
                dx = floor_shr(rad * sy + (longint'(1) << 29), 30);
                dy = floor_shr(rad * cx + (longint'(1) << 29), 30);
            end
            dx = clip(dx, -2 * (longint'(1) << 30), 2 * (longint'(1) << 30));
            dy = clip(dy, -2 * (longint'(1) << 30), 2 * (longint'(1) << 30));
        end
        rem = (longint'(1) << 60) - dx * dx - dy * dy;
        if (rem < 0) rem = 0;
        root = 0;
        for (int i = 31; i >= 0; i--) begin
            trial = root | (longint'(1) << i);
            if (trial * trial <= longint'(rem)) root = trial;
        end
        zq = longint'(root);
        d.dir_x = 16'(clip(floor_shr(dx + (1 << 14), 15), -32768, 32767));
        d.dir_y = 16'(clip(floor_shr(dy + (1 << 14), 15), -32768, 32767));
        d.dir_z = 15'(clip(floor_shr(zq + (1 << 14), 15), 0, 32767));
        pd = (zq * 341782638 + (longint'(1) << 43)) >>> 44;
        d.pdf = 15'(clip(pd, 0, 20861));
        return d;
    endfunction

    // Directed rows; the origin is typed in, the rest go through the predictor
    t_row dir_rows[20] = '{
        '{16'h8000, 16'h8000, 1'b1, '{16'sd0, 16'sd0, 15'd32767, 15'd20861}},
        '{16'h0000, 16'h8000, 1'b0, '{0, 0, 0, 0}},
        '{16'h0000, 16'h0000, 1'b0, '{0, 0, 0, 0}},
        '{16'hffff, 16'hffff, 1'b0, '{0, 0, 0, 0}},
        '{16'h0000, 16'hffff, 1'b0, '{0, 0, 0, 0}},
        '{16'hffff, 16'h0000, 1'b0, '{0, 0, 0, 0}},
        '{16'hffff, 16'h8000, 1'b0, '{0, 0, 0, 0}},
        '{16'h8000, 16'h0000, 1'b0, '{0, 0, 0, 0}},
        '{16'h8000, 16'hffff, 1'b0, '{0, 0, 0, 0}},
        '{16'h8001, 16'h8000, 1'b0, '{0, 0, 0, 0}},
        '{16'h8000, 16'h7fff, 1'b0, '{0, 0, 0, 0}},
        '{16'hc000, 16'hc000, 1'b0, '{0, 0, 0, 0}},
        '{16'h4000, 16'hc000, 1'b0, '{0, 0, 0, 0}},
        '{16'hc000, 16'h4000, 1'b0, '{0, 0, 0, 0}},
        '{16'h4000, 16'h4000, 1'b0, '{0, 0, 0, 0}},
        '{16'he000, 16'hc000, 1'b0, '{0, 0, 0, 0}},
        '{16'h9000, 16'h2000, 1'b0, '{0, 0, 0, 0}},
        '{16'h5555, 16'haaaa, 1'b0, '{0, 0, 0, 0}},
        '{16'haaaa, 16'h5555, 1'b0, '{0, 0, 0, 0}},
        '{16'h8001, 16'h7fff, 1'b0, '{0, 0, 0, 0}}
    };

    // Issue one request: raise start, wait for busy low at an edge, then queue the expected result
    task automatic send_request(input logic [15:0] ux, input logic [15:0] uy,
                                input bit known, input t_dir typed);
        start <= 1'b1;
        i_u_x <= ux;
        i_u_y <= uy;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        pending_dirs.push_back(known ? typed : sample_direction(ux, uy));
    endtask

    // Random gap: none half the time, else mostly short, sometimes long
    task automatic sender_gap();
        int n;
        n = $urandom_range(0, 9);
        n = n < 5 ? 0 : (n < 9 ? $urandom_range(1, 3) : $urandom_range(10, 120));
        if (n > 0) begin
            start <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // Stimulus
    initial begin
        logic [15:0] ux, uy;
        int sel;
        start     = 1'b0;
        i_u_x     = '0;
        i_u_y     = '0;
        i_rst_n   = 1'b0;
        stim_done = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (dir_rows[k]) begin
            send_request(dir_rows[k].u_x, dir_rows[k].u_y, dir_rows[k].known,
                         dir_rows[k].dir);
            sender_gap();
        end
        // drain fully once before random traffic
        start <= 1'b0;
        while (pending_dirs.size() != 0) @(posedge i_clk);
        for (int k = 0; k < RandCount; k++) begin
            sel = $urandom_range(0, 7);
            ux  = 16'($urandom);
            uy  = 16'($urandom);
            if (sel == 0) begin
                // diagonal, equal magnitudes
                uy = $urandom_range(0, 1) ? ux : 16'(17'h10000 - ux);
            end else if (sel == 1) begin
                // near the origin
                ux = 16'h8000 + 16'($urandom_range(0, 8)) - 16'd4;
                uy = 16'h8000 + 16'($urandom_range(0, 8)) - 16'd4;
            end else if (sel == 2) begin
                // along an edge of the square
                ux = $urandom_range(0, 1) ? 16'hffff : 16'h0000;
            end
            send_request(ux, uy, 1'b0, '{0, 0, 0, 0});
            sender_gap();
        end
        start     <= 1'b0;
        stim_done <= 1'b1;
    end

    // Result checker
    always @(posedge i_clk) begin
        t_dir exp_dir;
        if (i_rst_n && o_valid) begin
            if (pending_dirs.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("unexpected result x=%0d y=%0d z=%0d pdf=%0d",
                             o_dir_x, o_dir_y, o_dir_z, o_pdf);
            end else begin
                exp_dir = pending_dirs.pop_front();
                if (o_dir_x !== exp_dir.dir_x || o_dir_y !== exp_dir.dir_y ||
                    o_dir_z !== exp_dir.dir_z || o_pdf !== exp_dir.pdf) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("mismatch exp %0d %0d %0d %0d got %0d %0d %0d %0d",
                                 exp_dir.dir_x, exp_dir.dir_y, exp_dir.dir_z,
                                 exp_dir.pdf, o_dir_x, o_dir_y, o_dir_z, o_pdf);
                end
            end
        end
    end

    // End of run
    initial begin
        mismatch_cnt = 0;
        wait (stim_done);
        while (pending_dirs.size() != 0) @(posedge i_clk);
        repeat (Latency + 20) @(posedge i_clk);
        if (mismatch_cnt == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Timeout
    initial begin
        #(12 * 200000);
        $display("end of test: mismatches");
        $finish;
    end

endmodule
